@@ src/mss_pkg.sv @@
// Shared constants and types of the multichannel sample scheduler.
package mss_pkg;

	// Channel geometry
	localparam int CHANNELS  = 4;
	localparam int IDX_W     = 2;
	localparam int CNT_W     = 3;
	localparam int TIME_W    = 32;
	localparam int PIN_W     = 8;

	// Configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIN_MAP       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_0       = 3'd2;

	localparam logic [TIME_W-1:0] DELAY_RESET = 32'd1000;

	// Request to the remainder unit
	typedef struct packed {
		logic              start;
		logic [TIME_W-1:0] dividend;
		logic [TIME_W-1:0] divisor;
	} div_req_t;

	// Answer from the remainder unit
	typedef struct packed {
		logic              done;
		logic [TIME_W-1:0] rem;
	} div_rsp_t;

endpackage

@@ src/mss_rem_div.sv @@
// Bit-serial restoring divider that returns the remainder, one bit a cycle.
module mss_rem_div
	import mss_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(TIME_W);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] dvd_q;
	logic [TIME_W-1:0] dvs_q;

	logic [TIME_W:0]   shifted;
	logic [TIME_W:0]   trial;

	// Shift in the next dividend bit and try to subtract the divisor
	always_comb begin
		shifted = {rem_q, dvd_q[TIME_W-1]};
		trial   = shifted - {1'b0, dvs_q};
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(TIME_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (run_q) begin
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
			if (trial[TIME_W])
				rem_q <= shifted[TIME_W-1:0];
			else
				rem_q <= trial[TIME_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

@@ src/multichannel_sample_scheduler_top.sv @@
// Top level of the multichannel sample scheduler.
//
// Input channel: in_valid / in_stall with now_us, one timer tick per item.
// Output channel: out_valid / out_stall with channel, pin_id, sample_time and
// last; a tick gives zero to four requests, the final one marked by last.
// Configuration: cfg_we, cfg_index, cfg_wdata, to be written by the user while
// idle only; the block itself does not enforce this. A tick first has each
// channel in use checked for being due, one channel a cycle, then each due
// channel is served: its request is placed in the output register and its
// base time is advanced through the serial remainder unit, or set to the tick
// time if its delay is zero.
// in_stall stays high from acceptance until the sequencer has passed the last
// channel in use and is back in idle.
// The output register is separate from the sequencer, so the next tick can be
// accepted while the final request of a tick still waits to be taken.
// If the receiver stalls, the sequencer holds before loading the next request.
// Reset clears every base time to zero, sets channel_count and pin_map to
// zero and every delay to 1000, and leaves the output channel empty.
module multichannel_sample_scheduler_top
	import mss_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [TIME_W-1:0]    now_us,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [IDX_W-1:0]     channel,
	output logic [PIN_W-1:0]     pin_id,
	output logic [TIME_W-1:0]    sample_time,
	output logic                 last,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_PICK = 2'd2;
	localparam logic [1:0] S_DIV  = 2'd3;

	// Configuration registers
	logic [CNT_W-1:0]  count_cfg_q;
	logic [TIME_W-1:0] pin_map_q;
	logic [TIME_W-1:0] delay_q [CHANNELS];

	// Channel state
	logic [TIME_W-1:0] base_q [CHANNELS];

	// Sequencer
	logic [1:0]          state_q;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CHANNELS-1:0] mask_q;
	logic [TIME_W-1:0]   now_q;
	logic [TIME_W-1:0]   target_q;

	// Output register
	logic              out_valid_q;
	logic [IDX_W-1:0]  channel_q;
	logic [PIN_W-1:0]  pin_id_q;
	logic [TIME_W-1:0] sample_time_q;
	logic              last_q;

	logic [IDX_W-1:0]  cur;
	logic [TIME_W-1:0] cur_base;
	logic [TIME_W-1:0] cur_delay;
	logic [TIME_W-1:0] elapsed;
	logic              due;
	logic [TIME_W-1:0] target;
	logic [TIME_W-1:0] base_cl;
	logic [TIME_W-1:0] new_base;
	logic              in_take;
	logic              out_free;
	logic              load_out;
	logic [CNT_W-1:0]  count_clamped;

	div_req_t div_req;
	div_rsp_t div_rsp;

	function automatic logic later_due(input logic [CHANNELS-1:0] m,
	                                   input logic [IDX_W-1:0] i);
		logic r;
		r = 1'b0;
		for (int j = 0; j < CHANNELS; j++) begin
			if (j > int'(i) && m[j])
				r = 1'b1;
		end
		return r;
	endfunction

	// Current channel and its arithmetic
	always_comb begin
		cur       = idx_q[IDX_W-1:0];
		cur_base  = base_q[cur];
		cur_delay = delay_q[cur];
		elapsed   = now_q - cur_base;
		due       = elapsed >= cur_delay;
		target    = now_q - cur_delay;
		base_cl   = (cur_base > target) ? '0 : cur_base;
		if (div_rsp.rem == '0)
			new_base = target_q;
		else
			new_base = target_q + (cur_delay - div_rsp.rem);
		count_clamped = (count_cfg_q > CNT_W'(CHANNELS)) ? CNT_W'(CHANNELS) : count_cfg_q;
	end

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign load_out = (state_q == S_PICK) && (idx_q != cnt_q) && mask_q[cur] && out_free;

	// Start the remainder unit as the request goes out, unless the delay is zero
	always_comb begin
		div_req.start    = load_out && (cur_delay != '0);
		div_req.dividend = target - base_cl;
		div_req.divisor  = cur_delay;
	end

	mss_rem_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_cfg_q <= '0;
			pin_map_q   <= '0;
			for (int j = 0; j < CHANNELS; j++)
				delay_q[j] <= DELAY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHANNEL_COUNT: count_cfg_q <= cfg_wdata[CNT_W-1:0];
				REG_PIN_MAP:       pin_map_q   <= cfg_wdata;
				default: begin
					for (int j = 0; j < CHANNELS; j++) begin
						if (cfg_index == CFG_IDX_W'(int'(REG_DELAY_0) + j))
							delay_q[j] <= cfg_wdata;
					end
				end
			endcase
		end
	end

	// Sequencer: scan for due channels, then serve them in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
			mask_q  <= '0;
			for (int j = 0; j < CHANNELS; j++)
				base_q[j] <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						idx_q   <= '0;
						cnt_q   <= count_clamped;
						mask_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (idx_q == cnt_q) begin
						idx_q   <= '0;
						state_q <= S_PICK;
					end else begin
						mask_q[cur] <= due;
						idx_q       <= idx_q + 1'b1;
					end
				end
				S_PICK: begin
					if (idx_q == cnt_q) begin
						state_q <= S_IDLE;
					end else if (!mask_q[cur]) begin
						idx_q <= idx_q + 1'b1;
					end else if (out_free) begin
						if (cur_delay == '0) begin
							base_q[cur] <= now_q;
							idx_q       <= idx_q + 1'b1;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						base_q[cur] <= new_base;
						idx_q       <= idx_q + 1'b1;
						state_q     <= S_PICK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Tick time and target hold
	always_ff @(posedge clk) begin
		if (in_take)
			now_q <= now_us;
		if (load_out)
			target_q <= target;
	end

	// Output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			channel_q     <= cur;
			pin_id_q      <= pin_map_q[cur*PIN_W +: PIN_W];
			sample_time_q <= now_q;
			last_q        <= !later_due(mask_q, cur);
		end
	end

	assign out_valid   = out_valid_q;
	assign channel     = channel_q;
	assign pin_id      = pin_id_q;
	assign sample_time = sample_time_q;
	assign last        = last_q;

`ifndef SYNTHESIS
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("remainder done outside the divide state");

	a_div_due: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> mask_q[cur])
		else $error("dividing for a channel that is not due");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> idx_q <= cnt_q)
		else $error("channel index beyond the scanned count");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CHANNELS))
		else $error("scan count above the channel total");

	a_load_wait: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> state_q == S_DIV || state_q == S_PICK)
		else $error("sequencer left the serve loop after a request");
`endif

endmodule

@@ dv/tb_multichannel_sample_scheduler_top.sv @@
// Self-checking testbench for the multichannel sample scheduler top level.
`timescale 1ns / 100ps

module tb_multichannel_sample_scheduler_top;
	import mss_pkg::*;

	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 200;

	// Register slots with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [IDX_W-1:0]  chan;
		logic [PIN_W-1:0]  pin;
		logic [TIME_W-1:0] stamp;
		logic              fin;
	} sample_req_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [TIME_W-1:0]    now_us = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [IDX_W-1:0]     channel;
	logic [PIN_W-1:0]     pin_id;
	logic [TIME_W-1:0]    sample_time;
	logic                 last;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_wdata = '0;

	// Scheduler shadow state
	logic [CNT_W-1:0]  sched_count = '0;
	logic [TIME_W-1:0] sched_pins = '0;
	logic [TIME_W-1:0] sched_delay [CHANNELS];
	logic [TIME_W-1:0] sched_base [CHANNELS];

	sample_req_t sample_q [$];
	int          mismatches = 0;

	// Receiver idling control
	logic calm = 1'b0;
	logic hold_start = 1'b0;
	int   hold_left = 0;
	int   rx_run_left = 0;
	logic rx_busy = 1'b0;

	multichannel_sample_scheduler_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.now_us     (now_us),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.channel    (channel),
		.pin_id     (pin_id),
		.sample_time(sample_time),
		.last       (last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always #2 clk = ~clk;

	initial begin
		for (int i = 0; i < CHANNELS; i++) begin
			sched_delay[i] = DELAY_RESET;
			sched_base[i]  = '0;
		end
	end

	// Advance a base time past now - delay in whole periods
	function automatic logic [TIME_W-1:0] next_base(input logic [TIME_W-1:0] base,
			input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] d);
		logic [TIME_W-1:0] target;
		logic [TIME_W-1:0] b;
		logic [63:0]       diff;
		logic [63:0]       k;
		logic [63:0]       sum;
		if (d == '0) begin
			return t;
		end
		b = base;
		target = t - d;
		if (b > target) begin
			b = '0;
		end
		if (b < target) begin
			diff = {32'd0, target - b};
			k = (diff + {32'd0, d} - 64'd1) / {32'd0, d};
			sum = {32'd0, b} + k * {32'd0, d};
			b = sum[TIME_W-1:0];
		end
		return b;
	endfunction

	// Queue the sample requests that one tick raises
	function automatic void predict_requests(input logic [TIME_W-1:0] t);
		int          used;
		int          first;
		logic [TIME_W-1:0] age;
		sample_req_t req;
		first = sample_q.size();
		used = (sched_count > CHANNELS) ? CHANNELS : int'(sched_count);
		for (int i = 0; i < used; i++) begin
			age = t - sched_base[i];
			if (age >= sched_delay[i]) begin
				req.chan  = IDX_W'(i);
				req.pin   = sched_pins[8*i +: 8];
				req.stamp = t;
				req.fin   = 1'b0;
				sample_q.push_back(req);
				sched_base[i] = next_base(sched_base[i], t, sched_delay[i]);
			end
		end
		if (sample_q.size() > first) begin
			sample_q[sample_q.size()-1].fin = 1'b1;
		end
	endfunction

	function automatic logic [TIME_W-1:0] pick_delay();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			3: return $urandom();
			4: return $urandom_range(200, 3000);
			default: return $urandom_range(1, 200);
		endcase
	endfunction

	// Write one register and mirror it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_CHANNEL_COUNT) begin
			sched_count = val[CNT_W-1:0];
		end else if (idx == REG_PIN_MAP) begin
			sched_pins = val;
		end else if (idx >= REG_DELAY_0 && int'(idx) < int'(REG_DELAY_0) + CHANNELS) begin
			sched_delay[idx - REG_DELAY_0] = val;
		end
	endtask

	task automatic write_delays(input logic [TIME_W-1:0] d0, input logic [TIME_W-1:0] d1,
			input logic [TIME_W-1:0] d2, input logic [TIME_W-1:0] d3);
		write_reg(CFG_IDX_W'(REG_DELAY_0 + 0), d0);
		write_reg(CFG_IDX_W'(REG_DELAY_0 + 1), d1);
		write_reg(CFG_IDX_W'(REG_DELAY_0 + 2), d2);
		write_reg(CFG_IDX_W'(REG_DELAY_0 + 3), d3);
	endtask

	// Offer one tick, with an occasional gap in front of it
	task automatic send_tick(input logic [TIME_W-1:0] t);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_us   <= t;
		do @(posedge clk); while (in_stall);
		predict_requests(t);
	endtask

	// Stop offering, wait for every request, then let the sequencer finish
	task automatic wait_drained(input int extra);
		in_valid <= 1'b0;
		while (sample_q.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic report_mismatch(input sample_req_t want, input logic known);
		mismatches++;
		if (mismatches <= 10) begin
			if (known)
				$display("%0t: request mismatch: got ch %0d pin %h time %h last %b, want ch %0d pin %h time %h last %b",
					$realtime, channel, pin_id, sample_time, last,
					want.chan, want.pin, want.stamp, want.fin);
			else
				$display("%0t: unexpected request: ch %0d pin %h time %h last %b",
					$realtime, channel, pin_id, sample_time, last);
		end
	endtask

	// Check each accepted request against the oldest one predicted
	always @(posedge clk) begin : check_requests
		sample_req_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (sample_q.size() == 0) begin
				report_mismatch(want, 1'b0);
			end else begin
				want = sample_q.pop_front();
				if (channel !== want.chan || pin_id !== want.pin ||
						sample_time !== want.stamp || last !== want.fin)
					report_mismatch(want, 1'b1);
			end
		end
	end

	// Count down a long receiver hold-off
	always @(posedge clk) begin
		if (hold_start)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// Drive the receiver stall in random runs
	always @(posedge clk) begin
		if (rx_run_left == 0) begin
			rx_run_left <= $urandom_range(1, 18);
			rx_busy     <= ($urandom_range(0, 2) == 0);
		end else begin
			rx_run_left <= rx_run_left - 1;
		end
		out_stall <= (hold_left > 1) || (!calm && rx_busy && rx_run_left != 0);
	end

	// Reset values: no channel in use, then all four with default periods
	task automatic test_reset_defaults();
		send_tick(32'h0000_0000);
		send_tick(32'hFFFF_FFFF);
		wait_drained(DRAIN_CYCLES);
		write_reg(REG_CHANNEL_COUNT, 32'd4);
		send_tick(32'd1500);
		send_tick(32'd1600);
		wait_drained(DRAIN_CYCLES);
	endtask

	// Zero and full-range periods, time wrap, oversized count, spare slots
	task automatic test_special_cases();
		write_reg(REG_PIN_MAP, 32'hFF_C3_5A_00);
		write_delays(32'd1, 32'd1000, 32'hFFFF_FFFF, 32'd0);
		send_tick(32'h0000_0000);
		send_tick(32'h0000_0001);
		send_tick(32'd1000);
		send_tick(32'hFFFF_FFFF);
		send_tick(32'h0000_0000);
		send_tick(32'h8000_0000);
		send_tick(32'h7FFF_FFFF);
		send_tick(32'h0000_0001);
		wait_drained(DRAIN_CYCLES);
		write_reg(REG_CHANNEL_COUNT, 32'd7);
		send_tick(32'h8000_1234);
		send_tick(32'hFFFF_FFFE);
		wait_drained(DRAIN_CYCLES);
		write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_7, 32'h0000_0000);
		write_reg(REG_CHANNEL_COUNT, 32'd1);
		send_tick(32'hC000_0000);
		wait_drained(DRAIN_CYCLES);
		write_reg(REG_CHANNEL_COUNT, 32'd0);
		send_tick(32'h0000_0000);
		wait_drained(DRAIN_CYCLES);
	endtask

	// Fill the block behind a long receiver hold, then pause the sender
	task automatic test_backpressure();
		logic [TIME_W-1:0] t;
		write_reg(REG_CHANNEL_COUNT, 32'd4);
		write_reg(REG_PIN_MAP, $urandom());
		write_delays(32'd1, 32'd2, 32'd3, 32'd1);
		t = $urandom();
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		for (int i = 0; i < 8; i++) begin
			t = t + $urandom_range(3, 9);
			send_tick(t);
		end
		wait_drained(0);
		for (int i = 0; i < 6; i++) begin
			t = t + $urandom_range(0, 4);
			send_tick(t);
		end
		wait_drained(DRAIN_CYCLES);
	endtask

	// Random settings per phase, mostly steadily advancing time
	task automatic test_random_phases(input int phases, input int ticks);
		logic [TIME_W-1:0] t;
		logic [CNT_W-1:0]  cnt;
		for (int p = 0; p < phases; p++) begin
			cnt = ($urandom_range(0, 4) == 0) ? CNT_W'($urandom_range(0, 7)) : CNT_W'(CHANNELS);
			write_reg(REG_CHANNEL_COUNT, CFG_DAT_W'(cnt));
			write_reg(REG_PIN_MAP, $urandom());
			write_delays(pick_delay(), pick_delay(), pick_delay(), pick_delay());
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom());
			t = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 400) : $urandom();
			for (int i = 0; i < ticks; i++) begin
				case ($urandom_range(0, 19))
					0, 1: t = $urandom();
					2: t = t - $urandom_range(1, 300);
					default: t = t + $urandom_range(0, 160);
				endcase
				send_tick(t);
			end
			wait_drained(DRAIN_CYCLES);
		end
	endtask

	// Closing stretch with no idling on either side
	task automatic test_unbroken_tail();
		logic [TIME_W-1:0] t;
		calm <= 1'b1;
		write_reg(REG_CHANNEL_COUNT, 32'd4);
		write_reg(REG_PIN_MAP, $urandom());
		write_delays($urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(1, 40),
			$urandom_range(1, 40));
		t = $urandom();
		for (int i = 0; i < 40; i++) begin
			t = t + $urandom_range(0, 60);
			send_tick(t);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_special_cases();
		test_backpressure();
		test_random_phases(8, 30);
		test_unbroken_tail();
		wait_drained(DRAIN_CYCLES);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Guard against a hang
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
